// ----- rtl/bsph_pkg.sv -----
`timescale 1ns / 1ps
package bsph_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int SQ_WIDTH = 2 * DIFF_WIDTH;
   localparam int SUM_WIDTH = SQ_WIDTH + 2;
   localparam int AXES = 3;
   localparam int CORNERS = 8;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0] diff_type;
   typedef logic [SQ_WIDTH-1:0] sq_type;
   typedef logic [SUM_WIDTH-1:0] sum_type;

   typedef enum logic [1:0] {
      REL_DISJOINT = 2'd0,
      REL_INTERSECTS = 2'd1,
      REL_CONTAINS = 2'd2
   } rel_type;

   localparam logic [1:0] MODE_BOX = 2'd0;
   localparam logic [1:0] MODE_SPHERE = 2'd1;
   localparam logic [1:0] MODE_POINT = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic KIND_BOX = 1'b0;
   localparam logic KIND_SPHERE = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KIND = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_X_LO = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_Y_LO = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_Z_LO = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_X_HI = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_Y_HI = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_Z_HI = 3'd6;

   // Decisions taken in the first stage that ride along with the word.
   typedef struct packed {
      logic kind;
      logic [1:0] mode;
      logic bb_disj;
      logic bb_in;
      logic bp_disj;
      logic bp_edge;
      logic bs_in;
      logic r_neg;
      logic r_pos;
      logic s_neg;
      logic r1_ge_r2;
      logic [AXES-1:0] use_a;
      logic [AXES-1:0] use_b;
   } flags_type;

   function automatic sq_type sq_mag(input diff_type v);
      logic [DIFF_WIDTH-1:0] m;
      m = v[DIFF_WIDTH-1] ? DIFF_WIDTH'(-v) : DIFF_WIDTH'(v);
      return SQ_WIDTH'(m) * SQ_WIDTH'(m);
   endfunction

endpackage

// ----- rtl/bsph_front.sv -----
`timescale 1ns / 1ps
module bsph_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic kind,
   input  logic [1:0] mode,
   input  bsph_pkg::coord_type ref_lo [3],
   input  bsph_pkg::coord_type ref_hi [3],
   input  bsph_pkg::coord_type obj_lo [3],
   input  bsph_pkg::coord_type obj_hi [3],
   output logic valid_ff,
   output bsph_pkg::flags_type flags_ff,
   output bsph_pkg::diff_type a_ff [3],
   output bsph_pkg::diff_type b_ff [3],
   output bsph_pkg::diff_type rad_ff,
   output bsph_pkg::diff_type rsum_ff,
   output bsph_pkg::diff_type rdif_ff
);
   import bsph_pkg::*;

   flags_type flags_in;
   diff_type a_in [3];
   diff_type b_in [3];
   diff_type rad_in, rsum_in, rdif_in;

   always_comb begin
      diff_type q, p, l, h, h_q, r_obj, r_ref;
      r_obj = diff_type'(obj_hi[0]);
      r_ref = diff_type'(ref_hi[0]);
      flags_in = '0;
      flags_in.kind = kind;
      flags_in.mode = mode;
      flags_in.bb_in = 1'b1;
      flags_in.bs_in = 1'b1;
      for (int i = 0; i < AXES; i++) begin
         q = diff_type'(obj_lo[i]);
         p = diff_type'(obj_hi[i]);
         l = diff_type'(ref_lo[i]);
         h = diff_type'(ref_hi[i]);
         a_in[i] = q - l;
         h_q = h - q;
         b_in[i] = kind ? p - l : q - h;
         if (p < l || q > h) begin
            flags_in.bb_disj = 1'b1;
         end
         if (!(q >= l && p <= h)) begin
            flags_in.bb_in = 1'b0;
         end
         if (q < l || q > h) begin
            flags_in.bp_disj = 1'b1;
         end
         if (q == l || q == h) begin
            flags_in.bp_edge = 1'b1;
         end
         if (!(a_in[i] > r_obj && h_q > r_obj)) begin
            flags_in.bs_in = 1'b0;
         end
         // Clamp selection: box reference tests against the query radius,
         // sphere reference clamps its center to the query box.
         if (kind == KIND_BOX) begin
            flags_in.use_a[i] = (a_in[i] <= r_obj);
            flags_in.use_b[i] = !(a_in[i] <= r_obj) && (h_q <= r_obj);
         end else begin
            flags_in.use_a[i] = (l < q);
            flags_in.use_b[i] = !(l < q) && (l > p);
         end
      end
      rad_in = kind ? r_ref : r_obj;
      rsum_in = r_ref + r_obj;
      rdif_in = r_ref - r_obj;
      flags_in.r_neg = rad_in[DIFF_WIDTH-1];
      flags_in.r_pos = !rad_in[DIFF_WIDTH-1] && (rad_in != '0);
      flags_in.s_neg = rsum_in[DIFF_WIDTH-1];
      flags_in.r1_ge_r2 = !rdif_in[DIFF_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
      a_ff <= a_in;
      b_ff <= b_in;
      rad_ff <= rad_in;
      rsum_ff <= rsum_in;
      rdif_ff <= rdif_in;
   end

endmodule

// ----- rtl/bsph_square.sv -----
`timescale 1ns / 1ps
module bsph_square (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  bsph_pkg::flags_type flags,
   input  bsph_pkg::diff_type a [3],
   input  bsph_pkg::diff_type b [3],
   input  bsph_pkg::diff_type rad,
   input  bsph_pkg::diff_type rsum,
   input  bsph_pkg::diff_type rdif,
   output logic valid_ff,
   output bsph_pkg::flags_type flags_ff,
   output bsph_pkg::sq_type sa_ff [3],
   output bsph_pkg::sq_type sb_ff [3],
   output bsph_pkg::sq_type rr_ff,
   output bsph_pkg::sq_type ss_ff,
   output bsph_pkg::sq_type dd_ff
);
   import bsph_pkg::*;

   sq_type sa_in [3];
   sq_type sb_in [3];
   sq_type rr_in, ss_in, dd_in;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         sa_in[i] = sq_mag(a[i]);
         sb_in[i] = sq_mag(b[i]);
      end
      rr_in = sq_mag(rad);
      ss_in = sq_mag(rsum);
      dd_in = sq_mag(rdif);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags;
      sa_ff <= sa_in;
      sb_ff <= sb_in;
      rr_ff <= rr_in;
      ss_ff <= ss_in;
      dd_ff <= dd_in;
   end

endmodule

// ----- rtl/bsph_reduce.sv -----
`timescale 1ns / 1ps
module bsph_reduce (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  bsph_pkg::flags_type flags,
   input  bsph_pkg::sq_type sa [3],
   input  bsph_pkg::sq_type sb [3],
   input  bsph_pkg::sq_type rr,
   input  bsph_pkg::sq_type ss,
   input  bsph_pkg::sq_type dd,
   output logic out_valid_ff,
   output bsph_pkg::rel_type rel_ff
);
   import bsph_pkg::*;

   // Sum stage: eight corner distances and the clamped distance.
   logic sum_valid_ff;
   flags_type flags_ff;
   sum_type corner_ff [CORNERS];
   sum_type corner_in [CORNERS];
   sum_type clamp_ff, clamp_in;
   sq_type rr_ff, ss_ff, dd_ff;
   rel_type rel_in;

   always_comb begin
      for (int k = 0; k < CORNERS; k++) begin
         corner_in[k] = '0;
         for (int i = 0; i < AXES; i++) begin
            corner_in[k] = corner_in[k] + SUM_WIDTH'(k[i] ? sb[i] : sa[i]);
         end
      end
      clamp_in = '0;
      for (int i = 0; i < AXES; i++) begin
         if (flags.use_a[i]) begin
            clamp_in = clamp_in + SUM_WIDTH'(sa[i]);
         end else if (flags.use_b[i]) begin
            clamp_in = clamp_in + SUM_WIDTH'(sb[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= in_valid;
         out_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags;
      corner_ff <= corner_in;
      clamp_ff <= clamp_in;
      rr_ff <= rr;
      ss_ff <= ss;
      dd_ff <= dd;
      rel_ff <= rel_in;
   end

   // Decision stage. The all-low corner is the plain center distance.
   always_comb begin
      logic all_in;
      logic near;
      sum_type rr_w, ss_w, dd_w, ctr_d2;
      rr_w = SUM_WIDTH'(rr_ff);
      ss_w = SUM_WIDTH'(ss_ff);
      dd_w = SUM_WIDTH'(dd_ff);
      ctr_d2 = corner_ff[0];
      all_in = !flags_ff.r_neg;
      for (int k = 0; k < CORNERS; k++) begin
         if (corner_ff[k] > rr_w) begin
            all_in = 1'b0;
         end
      end
      near = (clamp_ff <= rr_w);
      rel_in = REL_DISJOINT;
      if (flags_ff.kind == KIND_BOX) begin
         case (flags_ff.mode)
            MODE_BOX: begin
               rel_in = flags_ff.bb_disj ? REL_DISJOINT :
                        flags_ff.bb_in ? REL_CONTAINS : REL_INTERSECTS;
            end
            MODE_SPHERE: begin
               rel_in = flags_ff.bs_in ? REL_CONTAINS :
                        near ? REL_INTERSECTS : REL_DISJOINT;
            end
            MODE_POINT: begin
               rel_in = flags_ff.bp_disj ? REL_DISJOINT :
                        flags_ff.bp_edge ? REL_INTERSECTS : REL_CONTAINS;
            end
            default: rel_in = REL_DISJOINT;
         endcase
      end else begin
         case (flags_ff.mode)
            MODE_BOX: begin
               rel_in = all_in ? REL_CONTAINS :
                        near ? REL_INTERSECTS : REL_DISJOINT;
            end
            MODE_SPHERE: begin
               if (flags_ff.s_neg || ctr_d2 > ss_w) begin
                  rel_in = REL_DISJOINT;
               end else if (flags_ff.r1_ge_r2 && ctr_d2 <= dd_w) begin
                  rel_in = REL_CONTAINS;
               end else begin
                  rel_in = REL_INTERSECTS;
               end
            end
            MODE_POINT: begin
               if (flags_ff.r_neg || ctr_d2 > rr_w) begin
                  rel_in = REL_DISJOINT;
               end else if (flags_ff.r_pos && ctr_d2 < rr_w) begin
                  rel_in = REL_CONTAINS;
               end else begin
                  rel_in = REL_INTERSECTS;
               end
            end
            default: rel_in = REL_DISJOINT;
         endcase
      end
   end

endmodule

// ----- rtl/box_sphere_point_hit_classifier.sv -----
`timescale 1ns / 1ps
// Classifies a box, sphere or point query against a reference box or sphere
// held in the csr_ registers, answering disjoint, intersects or contains.
// A word is taken on every cycle that start is high (busy never rises), and
// its answer appears on rsp_relation with rsp_valid after passing through
// one stage for differences and compares, one for the squaring
// multipliers, one for the distance sums and one for the final compares.
// One word per cycle is sustained. The receiver cannot stall the output.
// Write the reference registers only while no word is in flight.
module box_sphere_point_hit_classifier (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_mode,
   input  bsph_pkg::coord_type req_obj_x_lo,
   input  bsph_pkg::coord_type req_obj_y_lo,
   input  bsph_pkg::coord_type req_obj_z_lo,
   input  bsph_pkg::coord_type req_obj_x_hi,
   input  bsph_pkg::coord_type req_obj_y_hi,
   input  bsph_pkg::coord_type req_obj_z_hi,
   output logic rsp_valid,
   output logic [1:0] rsp_relation,
   input  logic csr_we,
   input  logic [bsph_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  bsph_pkg::coord_type csr_wdata
);
   import bsph_pkg::*;

   logic kind_ff;
   coord_type ref_lo_ff [3];
   coord_type ref_hi_ff [3];
   coord_type obj_lo [3];
   coord_type obj_hi [3];

   logic v1, v2;
   flags_type flags1, flags2;
   diff_type a1 [3];
   diff_type b1 [3];
   diff_type rad1, rsum1, rdif1;
   sq_type sa2 [3];
   sq_type sb2 [3];
   sq_type rr2, ss2, dd2;
   rel_type rel;

   assign busy = 1'b0;
   assign obj_lo[0] = req_obj_x_lo;
   assign obj_lo[1] = req_obj_y_lo;
   assign obj_lo[2] = req_obj_z_lo;
   assign obj_hi[0] = req_obj_x_hi;
   assign obj_hi[1] = req_obj_y_hi;
   assign obj_hi[2] = req_obj_z_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_BOX;
         for (int i = 0; i < AXES; i++) begin
            ref_lo_ff[i] <= '0;
            ref_hi_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            REG_KIND: kind_ff <= csr_wdata[0];
            REG_X_LO: ref_lo_ff[0] <= csr_wdata;
            REG_Y_LO: ref_lo_ff[1] <= csr_wdata;
            REG_Z_LO: ref_lo_ff[2] <= csr_wdata;
            REG_X_HI: ref_hi_ff[0] <= csr_wdata;
            REG_Y_HI: ref_hi_ff[1] <= csr_wdata;
            REG_Z_HI: ref_hi_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   bsph_front u_front (
      .clock(clock), .reset(reset), .in_valid(start && !busy),
      .kind(kind_ff), .mode(req_mode),
      .ref_lo(ref_lo_ff), .ref_hi(ref_hi_ff), .obj_lo(obj_lo), .obj_hi(obj_hi),
      .valid_ff(v1), .flags_ff(flags1), .a_ff(a1), .b_ff(b1),
      .rad_ff(rad1), .rsum_ff(rsum1), .rdif_ff(rdif1)
   );

   bsph_square u_square (
      .clock(clock), .reset(reset), .in_valid(v1), .flags(flags1),
      .a(a1), .b(b1), .rad(rad1), .rsum(rsum1), .rdif(rdif1),
      .valid_ff(v2), .flags_ff(flags2), .sa_ff(sa2), .sb_ff(sb2),
      .rr_ff(rr2), .ss_ff(ss2), .dd_ff(dd2)
   );

   bsph_reduce u_reduce (
      .clock(clock), .reset(reset), .in_valid(v2), .flags(flags2),
      .sa(sa2), .sb(sb2), .rr(rr2), .ss(ss2), .dd(dd2),
      .out_valid_ff(rsp_valid), .rel_ff(rel)
   );

   assign rsp_relation = rel;

`ifndef SYNTHESIS
   a_word_answered: assert property (@(posedge clock) disable iff (reset)
      start |-> ##4 rsp_valid)
      else $error("accepted word produced no answer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##4 !rsp_valid)
      else $error("answer without an accepted word");

   a_unused_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_mode, 4) == MODE_UNUSED)
      |-> rsp_relation == REL_DISJOINT)
      else $error("unused mode did not answer disjoint");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import bsph_pkg::*;

   typedef longint vec3_type[3];

   typedef struct {
      logic [1:0] mode;
      coord_type lo[3];
      coord_type hi[3];
   } query_type;

   class relation_scoreboard;
      rel_type pending[$];
      int errors = 0;

      function void note(rel_type expected);
         pending.push_back(expected);
      endfunction

      function void check(logic [1:0] actual);
         rel_type expected;
         if (pending.size() == 0) begin
            $display("%0t: unexpected relation word, expected none, actual %0d", $time, actual);
            errors++;
         end else begin
            expected = pending.pop_front();
            if (actual !== expected) begin
               $display("%0t: relation mismatch, expected %0d, actual %0d",
                        $time, expected, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_mode;
   coord_type req_obj_x_lo, req_obj_y_lo, req_obj_z_lo;
   coord_type req_obj_x_hi, req_obj_y_hi, req_obj_z_hi;
   logic rsp_valid;
   logic [1:0] rsp_relation;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   coord_type csr_wdata;

   relation_scoreboard relations = new();

   // Shadow copy of the reference volume registers.
   logic ref_kind_q;
   longint ref_lo_q[3];
   longint ref_hi_q[3];
   int idle_pct;

   box_sphere_point_hit_classifier u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode),
      .req_obj_x_lo(req_obj_x_lo), .req_obj_y_lo(req_obj_y_lo),
      .req_obj_z_lo(req_obj_z_lo), .req_obj_x_hi(req_obj_x_hi),
      .req_obj_y_hi(req_obj_y_hi), .req_obj_z_hi(req_obj_z_hi),
      .rsp_valid(rsp_valid), .rsp_relation(rsp_relation),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         relations.check(rsp_relation);
   end

   function automatic longint sq(longint a);
      return a * a;
   endfunction

   function automatic longint dist2(vec3_type a, vec3_type b);
      return sq(a[0] - b[0]) + sq(a[1] - b[1]) + sq(a[2] - b[2]);
   endfunction

   function automatic rel_type sphere_vs_point(vec3_type c, longint r, vec3_type p);
      longint d;
      d = dist2(c, p);
      if (r < 0 || d > sq(r))
         return REL_DISJOINT;
      if (r > 0 && d < sq(r))
         return REL_CONTAINS;
      return REL_INTERSECTS;
   endfunction

   function automatic rel_type box_vs_box(vec3_type lo, vec3_type hi,
                                          vec3_type qlo, vec3_type qhi);
      bit inside_all;
      inside_all = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (qhi[i] < lo[i] || qlo[i] > hi[i])
            return REL_DISJOINT;
         if (!(qlo[i] >= lo[i] && qhi[i] <= hi[i]))
            inside_all = 1'b0;
      end
      return inside_all ? REL_CONTAINS : REL_INTERSECTS;
   endfunction

   function automatic rel_type box_vs_sphere(vec3_type lo, vec3_type hi,
                                             vec3_type c, longint r);
      bit inside_all;
      longint d;
      inside_all = 1'b1;
      d = 0;
      for (int i = 0; i < 3; i++)
         if (!(c[i] - lo[i] > r && hi[i] - c[i] > r))
            inside_all = 1'b0;
      if (inside_all)
         return REL_CONTAINS;
      for (int i = 0; i < 3; i++) begin
         if (c[i] - lo[i] <= r)
            d += sq(c[i] - lo[i]);
         else if (hi[i] - c[i] <= r)
            d += sq(c[i] - hi[i]);
      end
      return (d <= sq(r)) ? REL_INTERSECTS : REL_DISJOINT;
   endfunction

   function automatic rel_type box_vs_point(vec3_type lo, vec3_type hi, vec3_type p);
      bit on_face;
      on_face = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (p[i] < lo[i] || p[i] > hi[i])
            return REL_DISJOINT;
         if (p[i] == lo[i] || p[i] == hi[i])
            on_face = 1'b1;
      end
      return on_face ? REL_INTERSECTS : REL_CONTAINS;
   endfunction

   function automatic rel_type sphere_vs_box(vec3_type c, longint r,
                                             vec3_type lo, vec3_type hi);
      vec3_type corner;
      longint d;
      bit all_in;
      all_in = 1'b1;
      d = 0;
      for (int k = 0; k < CORNERS; k++) begin
         for (int i = 0; i < 3; i++)
            corner[i] = k[i] ? hi[i] : lo[i];
         if (sphere_vs_point(c, r, corner) == REL_DISJOINT)
            all_in = 1'b0;
      end
      if (all_in)
         return REL_CONTAINS;
      for (int i = 0; i < 3; i++) begin
         if (c[i] < lo[i])
            d += sq(c[i] - lo[i]);
         else if (c[i] > hi[i])
            d += sq(c[i] - hi[i]);
      end
      return (d <= sq(r)) ? REL_INTERSECTS : REL_DISJOINT;
   endfunction

   function automatic rel_type sphere_vs_sphere(vec3_type c1, longint r1,
                                                vec3_type c2, longint r2);
      longint d;
      d = dist2(c1, c2);
      if (r1 + r2 < 0 || d > sq(r1 + r2))
         return REL_DISJOINT;
      if (r1 >= r2 && d <= sq(r1 - r2))
         return REL_CONTAINS;
      return REL_INTERSECTS;
   endfunction

   function automatic rel_type classify(query_type q);
      vec3_type qlo, qhi, rlo, rhi;
      for (int i = 0; i < 3; i++) begin
         qlo[i] = longint'(q.lo[i]);
         qhi[i] = longint'(q.hi[i]);
         rlo[i] = ref_lo_q[i];
         rhi[i] = ref_hi_q[i];
      end
      if (ref_kind_q == KIND_BOX) begin
         case (q.mode)
            MODE_BOX: return box_vs_box(rlo, rhi, qlo, qhi);
            MODE_SPHERE: return box_vs_sphere(rlo, rhi, qlo, qhi[0]);
            MODE_POINT: return box_vs_point(rlo, rhi, qlo);
            default: return REL_DISJOINT;
         endcase
      end
      case (q.mode)
         MODE_BOX: return sphere_vs_box(rlo, rhi[0], qlo, qhi);
         MODE_SPHERE: return sphere_vs_sphere(rlo, rhi[0], qlo, qhi[0]);
         MODE_POINT: return sphere_vs_point(rlo, rhi[0], qlo);
         default: return REL_DISJOINT;
      endcase
   endfunction

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] index, int value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= coord_type'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_KIND: ref_kind_q = value[0];
         REG_X_LO: ref_lo_q[0] = longint'(coord_type'(value));
         REG_Y_LO: ref_lo_q[1] = longint'(coord_type'(value));
         REG_Z_LO: ref_lo_q[2] = longint'(coord_type'(value));
         REG_X_HI: ref_hi_q[0] = longint'(coord_type'(value));
         REG_Y_HI: ref_hi_q[1] = longint'(coord_type'(value));
         REG_Z_HI: ref_hi_q[2] = longint'(coord_type'(value));
         default: ;
      endcase
   endtask

   task automatic set_reference(logic kind, int xl, int yl, int zl, int xh, int yh, int zh);
      write_reg(REG_KIND, int'(kind));
      write_reg(REG_X_LO, xl);
      write_reg(REG_Y_LO, yl);
      write_reg(REG_Z_LO, zl);
      write_reg(REG_X_HI, xh);
      write_reg(REG_Y_HI, yh);
      write_reg(REG_Z_HI, zh);
   endtask

   // Stop sending and let every word in flight come out.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (relations.pending.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic send_query(query_type q);
      req_mode <= q.mode;
      req_obj_x_lo <= q.lo[0];
      req_obj_y_lo <= q.lo[1];
      req_obj_z_lo <= q.lo[2];
      req_obj_x_hi <= q.hi[0];
      req_obj_y_hi <= q.hi[1];
      req_obj_z_hi <= q.hi[2];
      start <= 1'b1;
      do @(posedge clock); while (busy);
      relations.note(classify(q));
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send(logic [1:0] mode, int xl, int yl, int zl, int xh, int yh, int zh);
      query_type q;
      q.mode = mode;
      q.lo[0] = coord_type'(xl);
      q.lo[1] = coord_type'(yl);
      q.lo[2] = coord_type'(zl);
      q.hi[0] = coord_type'(xh);
      q.hi[1] = coord_type'(yh);
      q.hi[2] = coord_type'(zh);
      send_query(q);
   endtask

   function automatic int rand_coord(int center);
      case ($urandom_range(15))
         0, 1: return int'(coord_type'($urandom));
         2: return -32768;
         3: return 32767;
         default: return center + $urandom_range(0, 600) - 300;
      endcase
   endfunction

   task automatic random_reference();
      int xl, yl, zl;
      xl = rand_coord(0);
      yl = rand_coord(0);
      zl = rand_coord(0);
      if ($urandom_range(1)) begin
         // Sphere: mostly sane radius, sometimes zero, negative or huge.
         case ($urandom_range(7))
            0: set_reference(KIND_SPHERE, xl, yl, zl, 0, 0, 0);
            1: set_reference(KIND_SPHERE, xl, yl, zl, -$urandom_range(1, 200),
                             $urandom, $urandom);
            2: set_reference(KIND_SPHERE, xl, yl, zl, 32767, 0, 0);
            default: set_reference(KIND_SPHERE, xl, yl, zl, $urandom_range(1, 400),
                                   $urandom, $urandom);
         endcase
      end else if ($urandom_range(7) == 0) begin
         set_reference(KIND_BOX, xl, yl, zl, rand_coord(0), rand_coord(0), rand_coord(0));
      end else begin
         set_reference(KIND_BOX, xl, yl, zl, xl + $urandom_range(0, 400),
                       yl + $urandom_range(0, 400), zl + $urandom_range(0, 400));
      end
   endtask

   task automatic random_query();
      int cx, cy, cz;
      logic [1:0] mode;
      cx = int'(ref_lo_q[0]);
      cy = int'(ref_lo_q[1]);
      cz = int'(ref_lo_q[2]);
      mode = ($urandom_range(19) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
      case (mode)
         MODE_BOX: begin
            if ($urandom_range(7) == 0)
               send(mode, rand_coord(cx), rand_coord(cy), rand_coord(cz),
                    rand_coord(cx), rand_coord(cy), rand_coord(cz));
            else begin
               int xl, yl, zl;
               xl = rand_coord(cx);
               yl = rand_coord(cy);
               zl = rand_coord(cz);
               send(mode, xl, yl, zl, xl + $urandom_range(0, 300),
                    yl + $urandom_range(0, 300), zl + $urandom_range(0, 300));
            end
         end
         MODE_SPHERE:
            send(mode, rand_coord(cx), rand_coord(cy), rand_coord(cz),
                 ($urandom_range(9) == 0) ? int'(coord_type'($urandom))
                                           : $urandom_range(0, 300),
                 $urandom, $urandom);
         default:
            send(mode, rand_coord(cx), rand_coord(cy), rand_coord(cz),
                 $urandom, $urandom, $urandom);
      endcase
   endtask

   initial begin
      int pct[4];
      pct = '{0, 52, 0, 26};
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_BOX;
      req_obj_x_lo <= '0;
      req_obj_y_lo <= '0;
      req_obj_z_lo <= '0;
      req_obj_x_hi <= '0;
      req_obj_y_hi <= '0;
      req_obj_z_hi <= '0;
      csr_we <= 1'b0;
      csr_index <= REG_KIND;
      csr_wdata <= '0;
      ref_kind_q = KIND_BOX;
      ref_lo_q = '{0, 0, 0};
      ref_hi_q = '{0, 0, 0};
      idle_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset reference is a box collapsed onto the origin.
      send(MODE_POINT, 0, 0, 0, 0, 0, 0);
      send(MODE_BOX, 0, 0, 0, 0, 0, 0);
      drain();

      set_reference(KIND_BOX, -100, -100, -100, 100, 100, 100);
      write_reg(3'd7, 12345);
      send(MODE_BOX, -50, -50, -50, 50, 50, 50);
      send(MODE_BOX, -100, -100, -100, 100, 100, 100);
      send(MODE_BOX, 50, 50, 50, 150, 150, 150);
      send(MODE_BOX, 101, 0, 0, 200, 10, 10);
      send(MODE_BOX, -32768, -32768, -32768, 32767, 32767, 32767);
      send(MODE_SPHERE, 0, 0, 0, 10, 0, 0);
      send(MODE_SPHERE, 0, 0, 150, 50, 0, 0);
      send(MODE_SPHERE, 150, 150, 150, 60, 0, 0);
      send(MODE_SPHERE, 0, 0, 0, -5, 0, 0);
      send(MODE_POINT, 0, 0, 0, 0, 0, 0);
      send(MODE_POINT, 100, 0, 0, 0, 0, 0);
      send(MODE_POINT, 32767, -32768, 0, 0, 0, 0);
      send(MODE_UNUSED, 0, 0, 0, 0, 0, 0);
      drain();

      set_reference(KIND_SPHERE, 10, -20, 30, 100, 0, 0);
      send(MODE_POINT, 10, -20, 30, 0, 0, 0);
      send(MODE_POINT, 110, -20, 30, 0, 0, 0);
      send(MODE_POINT, 111, -20, 30, 0, 0, 0);
      send(MODE_SPHERE, 10, -20, 30, 100, 0, 0);
      send(MODE_SPHERE, 10, -20, 30, 150, 0, 0);
      send(MODE_SPHERE, 300, -20, 30, 5, 0, 0);
      send(MODE_BOX, 0, -30, 20, 20, -10, 40);
      send(MODE_BOX, 50, -20, 30, 500, 10, 40);
      send(MODE_UNUSED, 10, -20, 30, 0, 0, 0);
      drain();

      set_reference(KIND_SPHERE, -32768, -32768, -32768, 32767, 0, 0);
      send(MODE_BOX, -32768, -32768, -32768, 32767, 32767, 32767);
      send(MODE_SPHERE, 32767, 32767, 32767, 32767, 0, 0);
      send(MODE_POINT, 32767, 32767, 32767, 0, 0, 0);
      drain();

      for (int phase = 0; phase < 16; phase++) begin
         idle_pct = pct[phase % 4];
         random_reference();
         for (int n = 0; n < 60; n++)
            random_query();
         drain();
      end

      if (relations.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
